// ===== src/dit_pkg.sv =====
// dit_pkg: shared types and constants of the disjoint interval tracker
// used by the channel interfaces, the cell and the core; depends on nothing
`default_nettype none

package dit_pkg;

  localparam int unsigned FIELD_W = 16;

  typedef enum logic {
    REQ_ADD  = 1'b0,
    REQ_READ = 1'b1
  } req_type_e;

  typedef struct packed {
    logic read_step;
    logic add_go;
    logic join_left;
    logic join_right;
    logic insert;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/dit_if.sv =====
// dit_req_if and dit_rsp_if: valid/ready channels of the interval tracker
// depends on dit_pkg
`default_nettype none

interface dit_req_if import dit_pkg::*; ();
  logic                 valid;
  logic                 ready;
  req_type_e            req_type;
  logic [FIELD_W-1:0]   value;

  modport source (output valid, req_type, value, input ready);
  modport sink   (input valid, req_type, value, output ready);
endinterface

interface dit_rsp_if import dit_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 is_read_reply;
  logic                 add_status;
  logic                 has_interval;
  logic [FIELD_W-1:0]   interval_start;
  logic [FIELD_W-1:0]   interval_end;
  logic                 last_of_run;

  modport source (output valid, is_read_reply, add_status, has_interval,
                  interval_start, interval_end, last_of_run, input ready);
  modport sink   (input valid, is_read_reply, add_status, has_interval,
                  interval_start, interval_end, last_of_run, output ready);
endinterface

`default_nettype wire

// ===== src/dit_cell.sv =====
// dit_cell: one slot of the sorted interval chain, holds one interval
// and swaps data with its neighbors; depends on dit_pkg
`default_nettype none

module dit_cell import dit_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cell_ctrl_t             ctrl_i,
  input  wire logic [VALUE_WIDTH-1:0] value_i,
  input  wire logic                   prev_valid_i,
  input  wire logic [VALUE_WIDTH-1:0] prev_start_i,
  input  wire logic [VALUE_WIDTH-1:0] prev_end_i,
  input  wire logic                   prev_below_i,
  input  wire logic                   next_valid_i,
  input  wire logic [VALUE_WIDTH-1:0] next_start_i,
  input  wire logic [VALUE_WIDTH-1:0] next_end_i,
  output logic                        valid_o,
  output logic [VALUE_WIDTH-1:0]      start_o,
  output logic [VALUE_WIDTH-1:0]      end_o,
  output logic                        below_o,
  output logic                        join_left_o,
  output logic                        join_right_o,
  output logic                        covers_o
);

  logic                   valid_q, valid_d;
  logic [VALUE_WIDTH-1:0] start_q, start_d;
  logic [VALUE_WIDTH-1:0] end_q, end_d;
  logic                   end_lt;

  // neighbor tests one bit wider so the top value has no successor
  assign end_lt       = end_q < value_i;
  assign below_o      = valid_q & end_lt;
  assign covers_o     = valid_q & ~end_lt & (start_q <= value_i);
  assign join_left_o  = valid_q & (({1'b0, end_q} + 1'b1) == {1'b0, value_i});
  assign join_right_o = valid_q & ({1'b0, start_q} == ({1'b0, value_i} + 1'b1));

  assign valid_o = valid_q;
  assign start_o = start_q;
  assign end_o   = end_q;

  always_comb begin
    valid_d = valid_q;
    start_d = start_q;
    end_d   = end_q;
    if (ctrl_i.read_step) begin
      valid_d = next_valid_i;
      start_d = next_start_i;
      end_d   = next_end_i;
    end else if (ctrl_i.add_go) begin
      if (ctrl_i.join_left && ctrl_i.join_right) begin
        if (join_left_o) begin
          end_d = next_end_i;
        end else if (!below_o) begin
          valid_d = next_valid_i;
          start_d = next_start_i;
          end_d   = next_end_i;
        end
      end else if (ctrl_i.join_left) begin
        if (join_left_o) begin
          end_d = value_i;
        end
      end else if (ctrl_i.join_right) begin
        if (join_right_o) begin
          start_d = value_i;
        end
      end else if (ctrl_i.insert && !below_o) begin
        if (prev_below_i) begin
          valid_d = 1'b1;
          start_d = value_i;
          end_d   = value_i;
        end else begin
          valid_d = prev_valid_i;
          start_d = prev_start_i;
          end_d   = prev_end_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    end_q   <= end_d;
  end

endmodule

`default_nettype wire

// ===== src/disjoint_interval_tracker_core.sv =====
// disjoint_interval_tracker_core: top level, request control and result register
// depends on dit_pkg, dit_if and dit_cell
`default_nettype none

// Keeps a sorted set of disjoint closed intervals in a chain of MAX_INTERVALS
// cells, each holding one interval with a valid bit; the valid bits are the
// only chain state cleared by reset, so the block is ready right after reset
// with no clearing pass. For an add the request is taken, then
// every cell compares the value at once and the chain shifts, extends or joins
// in a single update, giving one acknowledgement (add_status set when a new
// entry is needed and all cells are in use); a result still waiting on the
// result side holds that update until it is taken. A read rotates the
// whole chain once around, pausing while a result waits on the result side,
// giving one interval per valid cell in ascending order with last_of_run on
// the final one, or a single has_interval = 0 result when the set is empty.
// Only the low VALUE_WIDTH bits of value are used.
module disjoint_interval_tracker_core import dit_pkg::*; #(
  parameter int unsigned MAX_INTERVALS = 32,
  parameter int unsigned VALUE_WIDTH   = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dit_req_if.sink   req_i,
  dit_rsp_if.source rsp_o
);

  localparam int unsigned CNT_W = $clog2(MAX_INTERVALS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_READ
  } state_e;

  state_e                 state_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [CNT_W-1:0]       rd_cnt_q;

  logic                   out_valid_q;
  logic                   out_read_q;
  logic                   out_status_q;
  logic                   out_has_q;
  logic [VALUE_WIDTH-1:0] out_start_q;
  logic [VALUE_WIDTH-1:0] out_end_q;
  logic                   out_last_q;

  logic [MAX_INTERVALS-1:0] valid_w;
  logic [MAX_INTERVALS-1:0] below_w;
  logic [MAX_INTERVALS-1:0] jl_w;
  logic [MAX_INTERVALS-1:0] jr_w;
  logic [MAX_INTERVALS-1:0] cov_w;
  logic [VALUE_WIDTH-1:0]   start_w [MAX_INTERVALS];
  logic [VALUE_WIDTH-1:0]   end_w   [MAX_INTERVALS];

  cell_ctrl_t ctrl;
  logic       out_free;
  logic       out_load;
  logic       covered;
  logic       any_jl;
  logic       any_jr;
  logic       full;
  logic       drop;
  logic       rd_emit;
  logic       rd_step;
  logic       rd_wrap;

  assign out_free = ~out_valid_q | rsp_o.ready;
  assign covered  = |cov_w;
  assign any_jl   = |jl_w;
  assign any_jr   = |jr_w;
  assign full     = valid_w[MAX_INTERVALS-1];
  assign drop     = ~covered & ~any_jl & ~any_jr & full;

  // empty set still answers once on the first read step
  assign rd_emit  = valid_w[0] | (rd_cnt_q == '0);
  assign rd_step  = (state_q == ST_READ) & (~rd_emit | out_free);
  assign rd_wrap  = rd_cnt_q == CNT_W'(MAX_INTERVALS - 1);
  assign out_load = ((state_q == ST_EVAL) & out_free) | (rd_step & rd_emit);

  always_comb begin
    ctrl            = '0;
    ctrl.read_step  = rd_step;
    ctrl.add_go     = (state_q == ST_EVAL) & out_free & ~covered;
    ctrl.join_left  = any_jl;
    ctrl.join_right = any_jr;
    ctrl.insert     = ~any_jl & ~any_jr & ~full;
  end

  for (genvar k = 0; k < MAX_INTERVALS; k++) begin : g_cell
    logic                   prev_valid;
    logic [VALUE_WIDTH-1:0] prev_start;
    logic [VALUE_WIDTH-1:0] prev_end;
    logic                   prev_below;
    logic                   next_valid;
    logic [VALUE_WIDTH-1:0] next_start;
    logic [VALUE_WIDTH-1:0] next_end;

    if (k == 0) begin : g_first
      assign prev_valid = 1'b0;
      assign prev_start = '0;
      assign prev_end   = '0;
      assign prev_below = 1'b1;
    end else begin : g_mid
      assign prev_valid = valid_w[k-1];
      assign prev_start = start_w[k-1];
      assign prev_end   = end_w[k-1];
      assign prev_below = below_w[k-1];
    end

    // the last cell wraps to the first one while reading, else pulls empty
    if (k == MAX_INTERVALS - 1) begin : g_last
      assign next_valid = rd_step & valid_w[0];
      assign next_start = start_w[0];
      assign next_end   = end_w[0];
    end else begin : g_inner
      assign next_valid = valid_w[k+1];
      assign next_start = start_w[k+1];
      assign next_end   = end_w[k+1];
    end

    dit_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .value_i      (value_q),
      .prev_valid_i (prev_valid),
      .prev_start_i (prev_start),
      .prev_end_i   (prev_end),
      .prev_below_i (prev_below),
      .next_valid_i (next_valid),
      .next_start_i (next_start),
      .next_end_i   (next_end),
      .valid_o      (valid_w[k]),
      .start_o      (start_w[k]),
      .end_o        (end_w[k]),
      .below_o      (below_w[k]),
      .join_left_o  (jl_w[k]),
      .join_right_o (jr_w[k]),
      .covers_o     (cov_w[k])
    );
  end

  assign req_i.ready          = state_q == ST_IDLE;
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.is_read_reply  = out_read_q;
  assign rsp_o.add_status     = out_status_q;
  assign rsp_o.has_interval   = out_has_q;
  assign rsp_o.interval_start = FIELD_W'(out_start_q);
  assign rsp_o.interval_end   = FIELD_W'(out_end_q);
  assign rsp_o.last_of_run    = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      value_q      <= '0;
      rd_cnt_q     <= '0;
      out_valid_q  <= 1'b0;
      out_read_q   <= 1'b0;
      out_status_q <= 1'b0;
      out_has_q    <= 1'b0;
      out_start_q  <= '0;
      out_end_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            value_q  <= VALUE_WIDTH'(req_i.value);
            rd_cnt_q <= '0;
            if (req_i.req_type == REQ_READ) begin
              state_q <= ST_READ;
            end else begin
              state_q <= ST_EVAL;
            end
          end
        end
        ST_EVAL: begin
          if (out_free) begin
            out_read_q   <= 1'b0;
            out_status_q <= drop;
            out_has_q    <= 1'b0;
            out_start_q  <= '0;
            out_end_q    <= '0;
            out_last_q   <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end
        ST_READ: begin
          if (rd_step) begin
            if (rd_emit) begin
              out_read_q   <= 1'b1;
              out_status_q <= 1'b0;
              out_has_q    <= valid_w[0];
              out_start_q  <= valid_w[0] ? start_w[0] : '0;
              out_end_q    <= valid_w[0] ? end_w[0] : '0;
              out_last_q   <= ~valid_w[0] | ~valid_w[1] | rd_wrap;
            end
            rd_cnt_q <= rd_cnt_q + 1'b1;
            if (rd_wrap) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // outside a read the occupied cells form a prefix of the chain
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_READ) |-> ((valid_w & (valid_w + 1'b1)) == '0))
    else $error("valid cells not contiguous");

  a_single_join: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> ($onehot0(jl_w) && $onehot0(jr_w)))
    else $error("more than one join candidate");

  a_cover_no_join: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_EVAL) && covered) |-> (!any_jl && !any_jr))
    else $error("covered value also touches a neighbor");

  a_add_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.add_go |=> ($countones(valid_w) <= $countones($past(valid_w)) + 1))
    else $error("add grew the set by more than one");

endmodule

`default_nettype wire
